@@ rtl/lcdx_pkg.sv @@
// ----------------------------------------------------------------------------
// lcdx_pkg
// Types, codes and constants for the 4-bit LCD port-expander sequencer.
// ----------------------------------------------------------------------------
package lcdx_pkg;

  // input command codes
  typedef enum logic [1:0] {
    CMD_CHAR   = 2'd0,
    CMD_CURSOR = 2'd1,
    CMD_LIGHT  = 2'd2,
    CMD_INIT   = 2'd3
  } cmd_t;

  // classified work for the back end
  typedef enum logic [1:0] {
    JOB_BYTE  = 2'd0,
    JOB_LIGHT = 2'd1,
    JOB_INIT  = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic        rs;
    logic [7:0]  value;
  } job_t;

  // character codes with special handling
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_FORMFEED   = 8'h0C;
  localparam logic [7:0] CH_PRINT_LO   = 8'h20;
  localparam logic [7:0] CH_PRINT_HI   = 8'h7E;

  // bytes sent for special characters
  localparam logic [7:0] LCD_DEGREE    = 8'hDF;
  localparam logic [7:0] LCD_CLEAR     = 8'h01;
  localparam logic [7:0] LCD_LINE_TWO  = 8'hC0;
  localparam logic [7:0] LCD_SET_DDRAM = 8'h80;

  // expander bit masks
  localparam logic [7:0] EXP_ENABLE    = 8'h04;
  localparam logic [7:0] EXP_BACKLIGHT = 8'h08;

  // init sequence: reset nibbles 3,3,8,2,2,8 then bytes 0x0C, 0x01, 0x03
  localparam int unsigned INIT_NIBBLES = 12;

  function automatic logic [3:0] init_nibble(input logic [3:0] idx);
    logic [3:0] n;
    case (idx)
      4'd0:    n = 4'h3;
      4'd1:    n = 4'h3;
      4'd2:    n = 4'h8;
      4'd3:    n = 4'h2;
      4'd4:    n = 4'h2;
      4'd5:    n = 4'h8;
      4'd6:    n = 4'h0;
      4'd7:    n = 4'hC;
      4'd8:    n = 4'h0;
      4'd9:    n = 4'h1;
      4'd10:   n = 4'h0;
      4'd11:   n = 4'h3;
      default: n = 4'h0;
    endcase
    return n;
  endfunction

endpackage

@@ rtl/lcdx_if.sv @@
// ----------------------------------------------------------------------------
// lcdx_if
// Valid/ready channels: LCD command items in, expander write items out.
// ----------------------------------------------------------------------------
interface lcdx_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] char_code;
  logic [6:0] position;
  logic       light_on;

  modport source (output valid, command, char_code, position, light_on,
                  input ready);
  modport sink   (input valid, command, char_code, position, light_on,
                  output ready);
endinterface

interface lcdx_wr_if;
  logic       valid;
  logic       ready;
  logic [7:0] expander_byte;
  logic       last;

  modport source (output valid, expander_byte, last, input ready);
  modport sink   (input valid, expander_byte, last, output ready);
endinterface

@@ rtl/lcd_4bit_expander_sequencer.sv @@
// ----------------------------------------------------------------------------
// lcd_4bit_expander_sequencer
// LCD commands in, port-expander write bytes out for a 4-bit character LCD.
// ----------------------------------------------------------------------------
// cmd carries one item per LCD command: show character, move cursor, set
// backlight or initialize. wr carries one item per expander write; last
// marks the final write caused by a command item.
// each LCD byte goes out as two nibbles, each nibble as three writes with
// enable low, high, low. character and cursor items give 6 writes, backlight
// 1 write, initialize 37 writes; unsupported character codes give none.
// the back end issues one write per cycle into the output register while
// wr does not stall. with the block idle a taken item passes the queue, the
// cur register and the output register before its first write is valid.
// a job queue of QUEUE_DEPTH entries lets cmd keep taking items while the
// back end works and while a write waits at wr.
// when wr stalls, the output register and the back end hold; once the
// queue is full cmd.ready drops.
// reset empties the queue, drops the output, turns the backlight bit off
// and clears the last written byte.
// ----------------------------------------------------------------------------
module lcd_4bit_expander_sequencer #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  lcdx_cmd_if.sink  cmd,
  lcdx_wr_if.source wr
);

  logic           full;
  logic           push;
  lcdx_pkg::job_t push_job;
  logic           pop;
  logic           head_valid;
  lcdx_pkg::job_t head_job;

  // classify items
  lcdx_front u_front (
    .cmd      (cmd),
    .full     (full),
    .push     (push),
    .push_job (push_job)
  );

  // job queue
  lcdx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // expand jobs into writes
  lcdx_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .wr         (wr)
  );

endmodule

@@ rtl/lcdx_front.sv @@
// ----------------------------------------------------------------------------
// lcdx_front
// Accepts command items and classifies them into jobs for the queue.
// ----------------------------------------------------------------------------
module lcdx_front (
  lcdx_cmd_if.sink      cmd,
  input  logic          full,
  output logic          push,
  output lcdx_pkg::job_t push_job
);

  lcdx_pkg::cmd_t cmd_code;
  logic           want;
  logic [7:0]     pos_ext;
  logic [7:0]     addr;

  assign cmd_code  = lcdx_pkg::cmd_t'(cmd.command);
  assign pos_ext   = {1'b0, cmd.position};
  assign cmd.ready = !full;
  assign push      = cmd.valid && !full && want;

  // row mapping: rows start at 0, 64, 20 and 84
  always_comb begin
    if (cmd.position > 7'd59) begin
      addr = pos_ext + 8'd24;
    end else if (cmd.position > 7'd39) begin
      addr = pos_ext - 8'd20;
    end else if (cmd.position > 7'd19) begin
      addr = pos_ext + 8'd44;
    end else begin
      addr = pos_ext;
    end
  end

  // classify
  always_comb begin
    want           = 1'b1;
    push_job.kind  = lcdx_pkg::JOB_BYTE;
    push_job.rs    = 1'b0;
    push_job.value = 8'h00;
    case (cmd_code)
      lcdx_pkg::CMD_CHAR: begin
        if (cmd.char_code >= lcdx_pkg::CH_PRINT_LO &&
            cmd.char_code <= lcdx_pkg::CH_PRINT_HI) begin
          push_job.rs    = 1'b1;
          push_job.value = cmd.char_code;
        end else if (cmd.char_code == lcdx_pkg::CH_TAB) begin
          push_job.rs    = 1'b1;
          push_job.value = lcdx_pkg::LCD_DEGREE;
        end else if (cmd.char_code == lcdx_pkg::CH_FORMFEED) begin
          push_job.value = lcdx_pkg::LCD_CLEAR;
        end else if (cmd.char_code == lcdx_pkg::CH_NEWLINE) begin
          push_job.value = lcdx_pkg::LCD_LINE_TWO;
        end else begin
          want = 1'b0;
        end
      end
      lcdx_pkg::CMD_CURSOR: begin
        push_job.value = addr + lcdx_pkg::LCD_SET_DDRAM;
      end
      lcdx_pkg::CMD_LIGHT: begin
        push_job.kind  = lcdx_pkg::JOB_LIGHT;
        push_job.value = {7'd0, cmd.light_on};
      end
      lcdx_pkg::CMD_INIT: begin
        push_job.kind  = lcdx_pkg::JOB_INIT;
      end
      default: begin
        want = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/lcdx_queue.sv @@
// ----------------------------------------------------------------------------
// lcdx_queue
// Small job queue between front and back end.
// ----------------------------------------------------------------------------
module lcdx_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lcdx_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output lcdx_pkg::job_t head_job
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  lcdx_pkg::job_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue popped while empty");

endmodule

@@ rtl/lcdx_back.sv @@
// ----------------------------------------------------------------------------
// lcdx_back
// Expands jobs into expander writes and holds the display-side state.
// ----------------------------------------------------------------------------
module lcdx_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  lcdx_pkg::job_t head_job,
  output logic           pop,
  lcdx_wr_if.source      wr
);

  // current job and its step counters
  logic           cur_valid;
  lcdx_pkg::job_t cur;
  logic [3:0]     nib_idx;
  logic [1:0]     phase;
  logic           lead;

  // display-side state
  logic           backlight;
  logic [7:0]     last_byte;

  // output register
  logic           out_valid;
  logic [7:0]     out_byte;
  logic           out_last;

  logic           slot_free;
  logic           emit;
  logic           final_step;
  logic [3:0]     nibble;
  logic           rs_bit;
  logic [7:0]     base_byte;
  logic [7:0]     light_byte;
  logic [7:0]     wr_byte;

  assign wr.valid         = out_valid;
  assign wr.expander_byte = out_byte;
  assign wr.last          = out_last;

  assign slot_free = wr.ready || !out_valid;
  assign emit      = cur_valid && slot_free;
  assign pop       = head_valid && (!cur_valid || (emit && final_step));

  // byte of the current step
  always_comb begin
    if (cur.kind == lcdx_pkg::JOB_INIT) begin
      nibble = lcdx_pkg::init_nibble(nib_idx);
    end else begin
      nibble = nib_idx[0] ? cur.value[3:0] : cur.value[7:4];
    end
    rs_bit     = (cur.kind == lcdx_pkg::JOB_BYTE) ? cur.rs : 1'b0;
    base_byte  = {nibble, backlight, 1'b0, 1'b0, rs_bit};
    light_byte = cur.value[0] ? (last_byte | lcdx_pkg::EXP_BACKLIGHT)
                              : (last_byte & ~lcdx_pkg::EXP_BACKLIGHT);
    case (cur.kind)
      lcdx_pkg::JOB_LIGHT: begin
        wr_byte    = light_byte;
        final_step = 1'b1;
      end
      lcdx_pkg::JOB_INIT: begin
        wr_byte    = lead ? 8'h00
                   : ((phase == 2'd1) ? (base_byte | lcdx_pkg::EXP_ENABLE) : base_byte);
        final_step = !lead && (phase == 2'd2) &&
                     (nib_idx == 4'(lcdx_pkg::INIT_NIBBLES - 1));
      end
      default: begin
        wr_byte    = (phase == 2'd1) ? (base_byte | lcdx_pkg::EXP_ENABLE) : base_byte;
        final_step = (phase == 2'd2) && (nib_idx == 4'd1);
      end
    endcase
  end

  // job sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      nib_idx   <= '0;
      phase     <= '0;
      lead      <= 1'b0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      nib_idx   <= '0;
      phase     <= '0;
      lead      <= (head_job.kind == lcdx_pkg::JOB_INIT);
    end else if (emit && final_step) begin
      cur_valid <= 1'b0;
    end else if (emit) begin
      if (lead) begin
        lead <= 1'b0;
      end else if (phase == 2'd2) begin
        phase   <= '0;
        nib_idx <= nib_idx + 4'd1;
      end else begin
        phase <= phase + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head_job;
    end
  end

  // backlight and last written byte
  always_ff @(posedge clk) begin
    if (rst) begin
      backlight <= 1'b0;
      last_byte <= 8'h00;
    end else if (emit) begin
      if (cur.kind == lcdx_pkg::JOB_LIGHT) begin
        backlight <= cur.value[0];
        last_byte <= light_byte;
      end else if (!lead && phase == 2'd2) begin
        last_byte <= base_byte;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (wr.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= wr_byte;
      out_last <= final_step;
    end
  end

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> phase != 2'd3)
    else $error("nibble phase out of range");

  a_lead_init: assert property (@(posedge clk) disable iff (rst)
    (cur_valid && lead) |-> (cur.kind == lcdx_pkg::JOB_INIT && nib_idx == 4'd0))
    else $error("leading zero write outside init job");

  a_byte_nibbles: assert property (@(posedge clk) disable iff (rst)
    (cur_valid && cur.kind == lcdx_pkg::JOB_BYTE) |-> nib_idx <= 4'd1)
    else $error("byte job ran past two nibbles");

endmodule

@@ verif/lcd_4bit_expander_sequencer_tb.sv @@
// ----------------------------------------------------------------------------
// lcd_4bit_expander_sequencer_tb
// Self-checking bench for the LCD port-expander sequencer. Command items are
// fed in bursts. Each expander write is predicted from the command stream and
// compared field by field. The write channel stalls at random and is held off
// once for a long stretch.
// ----------------------------------------------------------------------------
module lcd_4bit_expander_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_HALF     = 10;
  localparam int unsigned RESET_CYCLES = 9;
  localparam int unsigned ITEM_TARGET  = 330;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned MAX_REPORTS  = 30;

  // bytes of the init sequence that have no name in the package
  localparam logic [7:0] LCD_DISPLAY_ON = 8'h0C;
  localparam logic [7:0] LCD_INIT_TAIL  = 8'h03;
  localparam logic [7:0] EXP_IDLE_WRITE = 8'h00;

  typedef struct packed {
    lcdx_pkg::cmd_t command;
    logic [7:0]     code;
    logic [6:0]     pos;
    logic           bl;
  } lcd_cmd_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } exp_write_t;

  // expander write predictor and store of writes still to come
  class exp_write_scoreboard;
    logic        rs_mode;
    logic        light;
    logic [7:0]  prev_byte;
    exp_write_t  burst[$];
    exp_write_t  pending_writes[$];
    int unsigned mismatches;
    int unsigned writes_checked;

    function new();
      rs_mode        = 1'b0;
      light          = 1'b0;
      prev_byte      = '0;
      mismatches     = 0;
      writes_checked = 0;
    endfunction

    function void push_write(logic [7:0] b);
      exp_write_t w;
      w.data = b;
      w.last = 1'b0;
      burst.push_back(w);
    endfunction

    // one nibble: enable low, high, low
    function void push_nibble(logic [3:0] n);
      logic [7:0] b;
      b = {n, light, 1'b0, 1'b0, rs_mode};
      push_write(b);
      push_write(b | lcdx_pkg::EXP_ENABLE);
      push_write(b);
      prev_byte = b;
    endfunction

    function void push_byte(logic [7:0] v);
      push_nibble(v[7:4]);
      push_nibble(v[3:0]);
    endfunction

    // rows start at 0, 64, 20, 84; past position 103 the command byte wraps
    function logic [7:0] ddram_command(logic [6:0] pos);
      int unsigned p;
      int unsigned a;
      p = pos;
      if (p > 59) a = p + 24;
      else if (p > 39) a = p - 20;
      else if (p > 19) a = p + 44;
      else a = p;
      return 8'(a + lcdx_pkg::LCD_SET_DDRAM);
    endfunction

    // works out the writes of one accepted command, returns how many
    function int unsigned note_command(lcd_cmd_t c);
      burst.delete();
      case (c.command)
        lcdx_pkg::CMD_CHAR: begin
          if (c.code >= lcdx_pkg::CH_PRINT_LO && c.code <= lcdx_pkg::CH_PRINT_HI) begin
            rs_mode = 1'b1;
            push_byte(c.code);
          end else if (c.code == lcdx_pkg::CH_TAB) begin
            rs_mode = 1'b1;
            push_byte(lcdx_pkg::LCD_DEGREE);
          end else if (c.code == lcdx_pkg::CH_FORMFEED) begin
            rs_mode = 1'b0;
            push_byte(lcdx_pkg::LCD_CLEAR);
          end else if (c.code == lcdx_pkg::CH_NEWLINE) begin
            rs_mode = 1'b0;
            push_byte(lcdx_pkg::LCD_LINE_TWO);
          end
        end
        lcdx_pkg::CMD_CURSOR: begin
          rs_mode = 1'b0;
          push_byte(ddram_command(c.pos));
        end
        lcdx_pkg::CMD_LIGHT: begin
          light        = c.bl;
          prev_byte[3] = c.bl;
          push_write(prev_byte);
        end
        default: begin
          // blank write leaves prev_byte alone, then the 4-bit wake-up
          push_write(EXP_IDLE_WRITE);
          rs_mode = 1'b0;
          push_nibble(4'h3);
          push_nibble(4'h3);
          push_nibble(4'h8);
          push_nibble(4'h2);
          push_nibble(4'h2);
          push_nibble(4'h8);
          push_byte(LCD_DISPLAY_ON);
          push_byte(lcdx_pkg::LCD_CLEAR);
          push_byte(LCD_INIT_TAIL);
        end
      endcase
      if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
      foreach (burst[i]) pending_writes.push_back(burst[i]);
      return burst.size();
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("MISMATCH: %s", msg);
    endtask

    task check_write(logic [7:0] data, logic last);
      exp_write_t w;
      writes_checked++;
      if (pending_writes.size() == 0) begin
        report($sformatf("write %02h last %0b with nothing expected", data, last));
        return;
      end
      w = pending_writes.pop_front();
      if (data !== w.data)
        report($sformatf("write %0d: expander_byte %02h, expected %02h",
                         writes_checked, data, w.data));
      if (last !== w.last)
        report($sformatf("write %0d: last %0b, expected %0b",
                         writes_checked, last, w.last));
    endtask
  endclass

  logic clk;
  logic rst;

  lcdx_cmd_if cmd_bus ();
  lcdx_wr_if  wr_bus ();

  lcd_4bit_expander_sequencer u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_bus),
    .wr  (wr_bus)
  );

  exp_write_scoreboard sb = new();

  int unsigned items_sent    = 0;
  int unsigned ignored_items = 0;
  int unsigned holds_asked   = 0;
  int unsigned idle_cycles   = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // write channel monitor
  always @(posedge clk) begin
    if (!rst && wr_bus.valid === 1'b1 && wr_bus.ready === 1'b1)
      sb.check_write(wr_bus.expander_byte, wr_bus.last);
  end

  // watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if (rst || (cmd_bus.valid && cmd_bus.ready) || (wr_bus.valid && wr_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: nothing accepted for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: stall modes that change now and then, plus requested hold-offs
  initial begin
    int unsigned hold_left;
    int unsigned holds_done;
    int unsigned mode_left;
    int unsigned mode;
    int unsigned tick;
    logic        next_ready;
    hold_left  = 0;
    holds_done = 0;
    mode_left  = 0;
    mode       = 0;
    tick       = 0;
    wr_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_left == 0 && holds_done < holds_asked) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 4);
        mode_left = $urandom_range(16, 150);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else begin
        case (mode)
          0:       next_ready = 1'b1;
          1:       next_ready = ($urandom_range(0, 3) != 0);
          2:       next_ready = 1'($urandom_range(0, 1));
          3:       next_ready = ($urandom_range(0, 3) == 0);
          default: next_ready = ((tick % 7) >= 2);
        endcase
      end
      wr_bus.ready <= next_ready;
    end
  end

  // offer one command item and wait until it is taken
  task automatic send_item(lcd_cmd_t it);
    cmd_bus.valid     <= 1'b1;
    cmd_bus.command   <= it.command;
    cmd_bus.char_code <= it.code;
    cmd_bus.position  <= it.pos;
    cmd_bus.light_on  <= it.bl;
    @(posedge clk);
    while (cmd_bus.ready !== 1'b1) @(posedge clk);
    if (sb.note_command(it) == 0) ignored_items++;
    else items_sent++;
  endtask

  // gap between bursts, sometimes none
  task automatic idle_gap();
    if ($urandom_range(0, 3) != 0) begin
      cmd_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // stop sending until every expected write has come out
  task automatic wait_drained();
    cmd_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_writes.size() != 0) @(posedge clk);
  endtask

  function automatic lcd_cmd_t make_cmd(lcdx_pkg::cmd_t c, logic [7:0] code,
                                        logic [6:0] pos, logic bl);
    lcd_cmd_t it;
    it.command = c;
    it.code    = code;
    it.pos     = pos;
    it.bl      = bl;
    return it;
  endfunction

  // mostly printable text and cursor moves, some backlight items, specials, noise and inits
  function automatic lcd_cmd_t random_cmd();
    lcd_cmd_t    it;
    int unsigned pick;
    it   = make_cmd(lcdx_pkg::CMD_CHAR, 8'($urandom_range(0, 255)),
                    7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      it.code = 8'($urandom_range(lcdx_pkg::CH_PRINT_LO, lcdx_pkg::CH_PRINT_HI));
    end else if (pick < 57) begin
      case ($urandom_range(0, 2))
        0:       it.code = lcdx_pkg::CH_TAB;
        1:       it.code = lcdx_pkg::CH_NEWLINE;
        default: it.code = lcdx_pkg::CH_FORMFEED;
      endcase
    end else if (pick < 62) begin
      // any code at all, most of them ignored
    end else if (pick < 80) begin
      it.command = lcdx_pkg::CMD_CURSOR;
      if ($urandom_range(0, 6) != 0) it.pos = 7'($urandom_range(0, 79));
    end else if (pick < 95) begin
      it.command = lcdx_pkg::CMD_LIGHT;
    end else begin
      it.command = lcdx_pkg::CMD_INIT;
    end
    return it;
  endfunction

  // field extremes, every command and each special character
  task automatic run_directed();
    lcd_cmd_t list[$];
    list.push_back(make_cmd(lcdx_pkg::CMD_LIGHT,  8'h00,                 7'd0,   1'b1));
    list.push_back(make_cmd(lcdx_pkg::CMD_LIGHT,  8'hFF,                 7'd127, 1'b0));
    list.push_back(make_cmd(lcdx_pkg::CMD_INIT,   8'h00,                 7'd0,   1'b0));
    list.push_back(make_cmd(lcdx_pkg::CMD_CHAR,   lcdx_pkg::CH_PRINT_LO, 7'd0,   1'b0));
    list.push_back(make_cmd(lcdx_pkg::CMD_CHAR,   lcdx_pkg::CH_PRINT_HI, 7'd127, 1'b1));
    list.push_back(make_cmd(lcdx_pkg::CMD_CHAR,   lcdx_pkg::CH_TAB,      7'd0,   1'b0));
    list.push_back(make_cmd(lcdx_pkg::CMD_CHAR,   lcdx_pkg::CH_NEWLINE,  7'd0,   1'b0));
    list.push_back(make_cmd(lcdx_pkg::CMD_CHAR,   lcdx_pkg::CH_FORMFEED, 7'd0,   1'b0));
    list.push_back(make_cmd(lcdx_pkg::CMD_CHAR,   8'h00,                 7'd0,   1'b0));
    list.push_back(make_cmd(lcdx_pkg::CMD_CHAR,   8'h1F,                 7'd0,   1'b0));
    list.push_back(make_cmd(lcdx_pkg::CMD_CHAR,   8'h7F,                 7'd0,   1'b0));
    list.push_back(make_cmd(lcdx_pkg::CMD_CHAR,   8'hFF,                 7'd0,   1'b0));
    list.push_back(make_cmd(lcdx_pkg::CMD_CURSOR, 8'h00,                 7'd0,   1'b0));
    list.push_back(make_cmd(lcdx_pkg::CMD_CURSOR, 8'hFF,                 7'd19,  1'b1));
    list.push_back(make_cmd(lcdx_pkg::CMD_CURSOR, 8'h00,                 7'd20,  1'b0));
    list.push_back(make_cmd(lcdx_pkg::CMD_CURSOR, 8'h00,                 7'd39,  1'b0));
    list.push_back(make_cmd(lcdx_pkg::CMD_CURSOR, 8'h00,                 7'd40,  1'b0));
    list.push_back(make_cmd(lcdx_pkg::CMD_CURSOR, 8'h00,                 7'd59,  1'b0));
    list.push_back(make_cmd(lcdx_pkg::CMD_CURSOR, 8'h00,                 7'd60,  1'b0));
    list.push_back(make_cmd(lcdx_pkg::CMD_CURSOR, 8'h00,                 7'd79,  1'b0));
    list.push_back(make_cmd(lcdx_pkg::CMD_CURSOR, 8'h00,                 7'd80,  1'b0));
    list.push_back(make_cmd(lcdx_pkg::CMD_CURSOR, 8'h00,                 7'd127, 1'b0));
    list.push_back(make_cmd(lcdx_pkg::CMD_LIGHT,  8'h00,                 7'd0,   1'b1));
    list.push_back(make_cmd(lcdx_pkg::CMD_INIT,   8'hFF,                 7'd127, 1'b1));
    list.push_back(make_cmd(lcdx_pkg::CMD_LIGHT,  8'h00,                 7'd0,   1'b0));
    foreach (list[i]) begin
      send_item(list[i]);
      if ($urandom_range(0, 3) == 0) idle_gap();
    end
  endtask

  // random bursts; one long write hold-off with the sender still pushing
  task automatic run_random();
    int unsigned start;
    int unsigned burst_len;
    bit          hold_done;
    start     = items_sent;
    hold_done = 1'b0;
    while (items_sent - start < ITEM_TARGET) begin
      burst_len = $urandom_range(1, 24);
      repeat (burst_len) send_item(random_cmd());
      if (!hold_done && items_sent - start >= 120) begin
        hold_done = 1'b1;
        holds_asked <= holds_asked + 1;
        repeat (40) send_item(random_cmd());
        wait_drained();
      end else if ($urandom_range(0, 19) == 0) begin
        wait_drained();
      end else begin
        idle_gap();
      end
    end
  endtask

  // reset, stimulus and end of run
  initial begin
    rst               <= 1'b1;
    cmd_bus.valid     <= 1'b0;
    cmd_bus.command   <= lcdx_pkg::CMD_CHAR;
    cmd_bus.char_code <= '0;
    cmd_bus.position  <= '0;
    cmd_bus.light_on  <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    wait_drained();
    run_random();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d items with writes, %0d with ignored codes, %0d writes checked",
             items_sent, ignored_items, sb.writes_checked);
    $display("every command, special characters, row ends, wrap, init, %0d-cycle hold-off",
             HOLD_CYCLES);
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
